### design/preemptive_priority_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPSU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication, checked outside reset.
`define PPSU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

### design/ppsu_pkg.sv
// Constants and codes of the preemptive priority scheduler.
`default_nettype none

package ppsu_pkg;

	localparam int SLOT_W             = 4;
	localparam int CFG_W              = 5;
	localparam int DEF_MAX_PROCESSES  = 16;
	localparam int DEF_TIME_WIDTH     = 16;
	localparam int DEF_PRIORITY_WIDTH = 8;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

endpackage

`default_nettype wire

### design/preemptive_priority_scheduler_unit.sv
// Preemptive priority scheduler: slot memories, selection scan and tick update.
`default_nettype none
`include "preemptive_priority_scheduler_unit_defines.svh"

// Usage
//   Input words are taken at a rising edge with start high and busy low.
//   kind = load writes one process slot in that same edge and gives no result;
//   busy stays low, so loads can follow each other every cycle.
//   kind = tick starts a scan over the slots in use. The slot records sit in
//   synchronous memories, read one slot per cycle; the smallest ready
//   priority is kept in a running best register; after a wait state the
//   update state writes the decremented remaining time back and registers
//   the result. The scan covers used slots, where used = min(process_count,
//   MAX_PROCESSES); with none in use the scan is skipped. The result is shown on
//   the cycle in which busy falls, marked by result_valid for exactly one cycle.
//   The receiver cannot stall: the result must be taken in that cycle.
//   Configuration: cfg_data is written when cfg_valid and cfg_ready are high;
//   cfg_ready is low while a tick is in work.
//   Reset clears the time and the FSM, sets all done marks (every slot counts
//   as done until loaded) and sets process_count to 16. Slot memories are not
//   cleared; an unloaded slot is never picked because it is marked done.
module preemptive_priority_scheduler_unit
	import ppsu_pkg::*;
#(
	parameter int MAX_PROCESSES  = DEF_MAX_PROCESSES,
	parameter int TIME_WIDTH     = DEF_TIME_WIDTH,
	parameter int PRIORITY_WIDTH = DEF_PRIORITY_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output      logic                      busy,
	input  wire logic                      kind,
	input  wire logic [SLOT_W-1:0]         slot,
	input  wire logic [TIME_WIDTH-1:0]     arrive_at,
	input  wire logic [TIME_WIDTH-1:0]     burst_len,
	input  wire logic [PRIORITY_WIDTH-1:0] priority_level,
	input  wire logic                      cfg_valid,
	output      logic                      cfg_ready,
	input  wire logic [CFG_W-1:0]          cfg_data,
	output      logic                      result_valid,
	output      logic                      ran_valid,
	output      logic [SLOT_W-1:0]         ran_slot,
	output      logic                      finished,
	output      logic [TIME_WIDTH-1:0]     finish_time,
	output      logic [TIME_WIDTH-1:0]     turnaround,
	output      logic [TIME_WIDTH-1:0]     waiting,
	output      logic                      all_done
);

	localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

	typedef struct packed {
		logic [TIME_WIDTH-1:0]     arrival;
		logic [TIME_WIDTH-1:0]     burst;
		logic [PRIORITY_WIDTH-1:0] prio;
	} rec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_UPDATE
	} state_t;

	state_t                    state_q;
	logic [CFG_W-1:0]          count_q;
	logic [TIME_WIDTH-1:0]     time_q;
	logic [MAX_PROCESSES-1:0]  done_q;
	logic [IDX_W-1:0]          idx_q;
	logic [CNT_W-1:0]          undone_q;

	rec_t                      rec_mem [MAX_PROCESSES];
	logic [TIME_WIDTH-1:0]     rem_mem [MAX_PROCESSES];

	rec_t                      rec_s1;
	logic [TIME_WIDTH-1:0]     rem_s1;
	logic [IDX_W-1:0]          slot_s1;
	logic                      vld_s1;

	logic                      found_q;
	logic [IDX_W-1:0]          best_slot_q;
	rec_t                      best_rec_q;
	logic [TIME_WIDTH-1:0]     best_rem_q;

	logic                      result_valid_q;
	logic                      ran_valid_q;
	logic [SLOT_W-1:0]         ran_slot_q;
	logic                      finished_q;
	logic [TIME_WIDTH-1:0]     finish_time_q;
	logic [TIME_WIDTH-1:0]     turnaround_q;
	logic [TIME_WIDTH-1:0]     waiting_q;
	logic                      all_done_q;

	logic                      accept;
	logic                      load_acc;
	logic                      tick_acc;
	logic                      load_ok;
	logic [IDX_W-1:0]          load_idx;
	logic [CNT_W-1:0]          used;
	logic                      scan_last;
	logic                      cand;
	logic                      cand_undone;
	logic [TIME_WIDTH-1:0]     time_nx;
	logic [TIME_WIDTH-1:0]     rem_nx;
	logic                      fin;
	logic [TIME_WIDTH-1:0]     tat;
	logic [TIME_WIDTH-1:0]     wt;
	logic [CNT_W-1:0]          undone_nx;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = ~busy;
	assign accept    = start & ~busy;
	assign load_acc  = accept & (kind == KIND_LOAD);
	assign tick_acc  = accept & (kind == KIND_TICK);
	assign load_ok   = (int'(slot) < MAX_PROCESSES);
	assign load_idx  = IDX_W'(slot);

	always_comb begin
		if (int'(count_q) > MAX_PROCESSES) begin
			used = CNT_W'(MAX_PROCESSES);
		end else begin
			used = CNT_W'(count_q);
		end
	end

	assign scan_last   = (CNT_W'(idx_q) == (used - CNT_W'(1)));
	assign cand_undone = vld_s1 & ~done_q[slot_s1];
	// strict compare keeps the lowest slot on equal priority
	assign cand = cand_undone && (rec_s1.arrival <= time_q) &&
		(!found_q || (rec_s1.prio < best_rec_q.prio));

	// tick update, used in the update state only
	assign time_nx   = (time_q == '1) ? time_q : time_q + TIME_WIDTH'(1);
	assign rem_nx    = (best_rem_q == '0) ? '0 : best_rem_q - TIME_WIDTH'(1);
	assign fin       = found_q & (rem_nx == '0);
	assign tat       = time_nx - best_rec_q.arrival;
	assign wt        = (tat >= best_rec_q.burst) ? tat - best_rec_q.burst : '0;
	assign undone_nx = fin ? undone_q - CNT_W'(1) : undone_q;

	// slot record memory: written by loads, read one slot per scan cycle
	always_ff @(posedge clk) begin
		if (load_acc && load_ok) begin
			rec_mem[load_idx] <= '{arrival: arrive_at, burst: burst_len,
				prio: priority_level};
		end
		rec_s1 <= rec_mem[idx_q];
	end

	// remaining-time memory: written by loads and by the tick write-back
	always_ff @(posedge clk) begin
		if (load_acc && load_ok) begin
			rem_mem[load_idx] <= burst_len;
		end else if (state_q == ST_UPDATE && found_q) begin
			rem_mem[best_slot_q] <= rem_nx;
		end
		rem_s1  <= rem_mem[idx_q];
		slot_s1 <= idx_q;
	end

	// best-so-far payload
	always_ff @(posedge clk) begin
		if (cand) begin
			best_slot_q <= slot_s1;
			best_rec_q  <= rec_s1;
			best_rem_q  <= rem_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= CFG_RESET;
			time_q         <= '0;
			done_q         <= '1;
			idx_q          <= '0;
			undone_q       <= '0;
			vld_s1         <= 1'b0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
			ran_valid_q    <= 1'b0;
			ran_slot_q     <= '0;
			finished_q     <= 1'b0;
			finish_time_q  <= '0;
			turnaround_q   <= '0;
			waiting_q      <= '0;
			all_done_q     <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			vld_s1         <= (state_q == ST_SCAN);
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (cand_undone) begin
				undone_q <= undone_q + CNT_W'(1);
			end
			if (cand) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (load_acc && load_ok) begin
						done_q[load_idx] <= (burst_len == '0);
					end
					if (tick_acc) begin
						idx_q    <= '0;
						undone_q <= '0;
						found_q  <= 1'b0;
						state_q  <= (used == '0) ? ST_UPDATE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_WAIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_WAIT: begin
					// let the last slot's compare land
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					time_q         <= time_nx;
					if (fin) begin
						done_q[best_slot_q] <= 1'b1;
					end
					result_valid_q <= 1'b1;
					ran_valid_q    <= found_q;
					ran_slot_q     <= found_q ? SLOT_W'(best_slot_q) : '0;
					finished_q     <= fin;
					finish_time_q  <= time_nx;
					turnaround_q   <= fin ? tat : '0;
					waiting_q      <= fin ? wt : '0;
					all_done_q     <= (undone_nx == '0);
					idx_q          <= '0;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign ran_valid    = ran_valid_q;
	assign ran_slot     = ran_slot_q;
	assign finished     = finished_q;
	assign finish_time  = finish_time_q;
	assign turnaround   = turnaround_q;
	assign waiting      = waiting_q;
	assign all_done     = all_done_q;

	`PPSU_ASSERT_NXT(a_strobe_single, result_valid_q, !result_valid_q)
	`PPSU_ASSERT_IMP(a_finish_needs_run, result_valid_q && finished_q, ran_valid_q)
	`PPSU_ASSERT_NXT(a_tick_goes_busy, tick_acc, state_q != ST_IDLE)
	`PPSU_ASSERT_NXT(a_update_ends, state_q == ST_UPDATE, result_valid_q && state_q == ST_IDLE)

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the preemptive priority scheduler unit.
`timescale 1ns / 1ps

module tb
	import ppsu_pkg::*;
();

	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 200_000;
	localparam int RANDOM_WORDS  = 780;
	localparam int NSLOT         = DEF_MAX_PROCESSES;
	localparam int TW            = DEF_TIME_WIDTH;
	localparam int PW            = DEF_PRIORITY_WIDTH;

	typedef enum logic {ENT_WORD, ENT_CFG} entry_kind_t;

	typedef struct {
		entry_kind_t       what;
		logic              kind;
		logic [SLOT_W-1:0] slot;
		logic [TW-1:0]     arr;
		logic [TW-1:0]     bst;
		logic [PW-1:0]     prio;
		logic [CFG_W-1:0]  cfg_val;
		bit                no_idle;
	} sched_word_t;

	typedef struct packed {
		logic              ran_valid;
		logic [SLOT_W-1:0] ran_slot;
		logic              finished;
		logic [TW-1:0]     finish_time;
		logic [TW-1:0]     turnaround;
		logic [TW-1:0]     waiting;
		logic              all_done;
	} tick_report_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              kind = KIND_LOAD;
	logic [SLOT_W-1:0] slot = '0;
	logic [TW-1:0]     arrive_at = '0;
	logic [TW-1:0]     burst_len = '0;
	logic [PW-1:0]     priority_level = '0;
	logic              cfg_valid = 1'b0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              busy, cfg_ready, result_valid;
	logic              ran_valid, finished, all_done;
	logic [SLOT_W-1:0] ran_slot;
	logic [TW-1:0]     finish_time, turnaround, waiting;

	preemptive_priority_scheduler_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.slot           (slot),
		.arrive_at      (arrive_at),
		.burst_len      (burst_len),
		.priority_level (priority_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.ran_valid      (ran_valid),
		.ran_slot       (ran_slot),
		.finished       (finished),
		.finish_time    (finish_time),
		.turnaround     (turnaround),
		.waiting        (waiting),
		.all_done       (all_done)
	);

	sched_word_t  pend_q[$];
	tick_report_t tick_reports_q[$];

	// scheduler state as the testbench sees it
	logic [TW-1:0]    slot_arrival[NSLOT];
	logic [TW-1:0]    slot_burst[NSLOT];
	logic [TW-1:0]    slot_left[NSLOT];
	logic [PW-1:0]    slot_prio[NSLOT];
	bit               slot_done[NSLOT];
	logic [TW-1:0]    clock_now;
	logic [CFG_W-1:0] slots_used;

	int  mismatches = 0;
	int  report_idx = 0;
	int  cycle_cnt = 0;
	int  gap_left = 0;
	int  quiet_cycles = 0;
	int  calm_left = 0;
	bit  calm = 1'b0;
	int  gen_time = 0;
	bit  gen_quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void store_process(input logic [SLOT_W-1:0] s, input logic [TW-1:0] a,
			input logic [TW-1:0] b, input logic [PW-1:0] p);
		slot_arrival[s] = a;
		slot_burst[s] = b;
		slot_left[s] = b;
		slot_prio[s] = p;
		slot_done[s] = (b == '0);
	endfunction

	function automatic tick_report_t advance_tick();
		tick_report_t r;
		int           n_used;
		int           pick;
		logic [PW-1:0] best;
		logic [TW-1:0] span;
		r = '0;
		pick = -1;
		best = '0;
		n_used = (slots_used > NSLOT) ? NSLOT : int'(slots_used);
		for (int i = 0; i < n_used; i++) begin
			if (!slot_done[i] && slot_arrival[i] <= clock_now && (pick < 0 || slot_prio[i] < best)) begin
				pick = i;
				best = slot_prio[i];
			end
		end
		// time sticks at its maximum
		if (clock_now != '1)
			clock_now = clock_now + 1'b1;
		if (pick >= 0) begin
			r.ran_valid = 1'b1;
			r.ran_slot = pick[SLOT_W-1:0];
			if (slot_left[pick] != '0)
				slot_left[pick] = slot_left[pick] - 1'b1;
			if (slot_left[pick] == '0) begin
				slot_done[pick] = 1'b1;
				span = clock_now - slot_arrival[pick];
				r.finished = 1'b1;
				r.turnaround = span;
				r.waiting = (span >= slot_burst[pick]) ? span - slot_burst[pick] : '0;
			end
		end
		r.finish_time = clock_now;
		r.all_done = 1'b1;
		for (int i = 0; i < n_used; i++)
			if (!slot_done[i])
				r.all_done = 1'b0;
		return r;
	endfunction

	task automatic push_load(input int s, input int a, input int b, input int p);
		sched_word_t w;
		w = '{what: ENT_WORD, kind: KIND_LOAD, slot: s[SLOT_W-1:0], arr: a[TW-1:0],
			bst: b[TW-1:0], prio: p[PW-1:0], cfg_val: '0, no_idle: gen_quiet};
		pend_q.push_back(w);
	endtask

	task automatic push_tick();
		sched_word_t w;
		w = '{what: ENT_WORD, kind: KIND_TICK, slot: SLOT_W'($urandom), arr: TW'($urandom),
			bst: TW'($urandom), prio: PW'($urandom), cfg_val: '0, no_idle: gen_quiet};
		pend_q.push_back(w);
		if (gen_time < 65535)
			gen_time++;
	endtask

	task automatic push_cfg(input int v);
		sched_word_t w;
		w = '{what: ENT_CFG, kind: KIND_LOAD, slot: '0, arr: '0, bst: '0, prio: '0,
			cfg_val: v[CFG_W-1:0], no_idle: gen_quiet};
		pend_q.push_back(w);
	endtask

	task automatic fill_stimulus();
		int v, n_used, roll, s, a, rand_words;
		rand_words = 0;
		// directed: ties, priority zero, zero burst, reload while running, unused slots
		push_cfg(4);
		push_load(0, 0, 3, 5);
		push_load(1, 0, 2, 5);
		push_load(2, 2, 1, 0);
		push_load(3, 0, 0, 1);
		push_load(9, 0, 4, 3);
		push_tick();
		push_tick();
		push_load(0, 0, 2, 5);
		repeat (6) push_tick();
		push_cfg(0);
		repeat (2) push_tick();
		push_cfg(31);
		repeat (3) push_tick();
		push_load(15, 65535, 65535, 255);

		while (rand_words < RANDOM_WORDS) begin
			// no idling over the last stretch
			if (rand_words >= RANDOM_WORDS - 100)
				gen_quiet = 1'b1;
			case ($urandom_range(0, 5))
				0: v = 16;
				1: v = $urandom_range(17, 31);
				2: v = $urandom_range(1, 3);
				default: v = $urandom_range(0, 31);
			endcase
			push_cfg(v);
			n_used = (v > NSLOT) ? NSLOT : v;
			repeat ($urandom_range(40, 100)) begin
				roll = $urandom_range(0, 99);
				if (roll < 30) begin
					if (n_used == 0 || $urandom_range(0, 6) == 0)
						s = $urandom_range(0, NSLOT - 1);
					else
						s = $urandom_range(0, n_used - 1);
					a = gen_time + $urandom_range(0, 6);
					if (a > 65535)
						a = 65535;
					push_load(s, a, $urandom_range(1, 10),
						$urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(0, 255));
				end else if (roll < 36) begin
					push_load($urandom_range(0, 15), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 255));
				end else begin
					push_tick();
				end
				rand_words++;
			end
		end

		// close with a few slots finishing and one that never arrives
		gen_quiet = 1'b1;
		push_cfg(3);
		push_load(0, gen_time, 10, 1);
		push_load(1, gen_time + 1, 2, 0);
		push_load(2, 65535, 1, 0);
		repeat (14) push_tick();
	endtask

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			slot_arrival[i] = '0;
			slot_burst[i] = '0;
			slot_left[i] = '0;
			slot_prio[i] = '0;
			slot_done[i] = 1'b1;
		end
		clock_now = '0;
		slots_used = CFG_RESET;
		fill_stimulus();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (pend_q.size() != 0 || start || cfg_valid || tick_reports_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += tick_reports_q.size();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		sched_word_t w;
		logic        nxt_start;
		logic        nxt_cfg_valid;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			gap_left <= 0;
			quiet_cycles <= 0;
		end else begin
			nxt_start = start;
			nxt_cfg_valid = cfg_valid;
			if (start && !busy) begin
				if (kind == KIND_TICK)
					tick_reports_q.push_back(advance_tick());
				else
					store_process(slot, arrive_at, burst_len, priority_level);
				nxt_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				slots_used = cfg_data;
				nxt_cfg_valid = 1'b0;
			end
			if ((start && !busy) || result_valid)
				quiet_cycles <= 0;
			else if (quiet_cycles < SETTLE_CYCLES)
				quiet_cycles <= quiet_cycles + 1;
			if (!nxt_start && !nxt_cfg_valid) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (pend_q.size() != 0) begin
					if (pend_q[0].what == ENT_WORD) begin
						w = pend_q.pop_front();
						kind <= w.kind;
						slot <= w.slot;
						arrive_at <= w.arr;
						burst_len <= w.bst;
						priority_level <= w.prio;
						nxt_start = 1'b1;
						if (calm_left == 0) begin
							calm = ($urandom_range(0, 2) == 0);
							calm_left = $urandom_range(16, 48);
						end else begin
							calm_left--;
						end
						if (!w.no_idle && !calm && $urandom_range(0, 3) == 0)
							gap_left <= $urandom_range(1, 8);
					end else if (tick_reports_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
						// write the register only once the block has settled
						w = pend_q.pop_front();
						cfg_data <= w.cfg_val;
						nxt_cfg_valid = 1'b1;
					end
				end
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg_valid;
		end
	end

	task automatic check_field(input string name, input logic [TW-1:0] want, input logic [TW-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("tick report %0d: %s expected %0d, got %0d", report_idx, name, want, got);
		end
	endtask

	// monitor
	always @(posedge clk) begin
		tick_report_t want;
		if (arst_n && result_valid) begin
			if (tick_reports_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tick report %0d: word with no pending tick", report_idx);
			end else begin
				want = tick_reports_q.pop_front();
				check_field("ran_valid", TW'(want.ran_valid), TW'(ran_valid));
				check_field("ran_slot", TW'(want.ran_slot), TW'(ran_slot));
				check_field("finished", TW'(want.finished), TW'(finished));
				check_field("finish_time", want.finish_time, finish_time);
				check_field("turnaround", want.turnaround, turnaround);
				check_field("waiting", want.waiting, waiting);
				check_field("all_done", TW'(want.all_done), TW'(all_done));
			end
			report_idx++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

### sim.f
+incdir+design
design/ppsu_pkg.sv
design/preemptive_priority_scheduler_unit.sv
test/tb.sv
